// ===== rtl/core/lsfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_pkg
// shared constants, types and the line-bit expansion for the frame encoder
// ----------------------------------------------------------------------------
package lsfe_pkg;

    localparam int LED_COUNT_DEF = 7;
    localparam int STORE_DEPTH   = 7;
    localparam int PIX_W         = 3;
    localparam int CNT_W         = 4;
    localparam int COLOUR_W      = 24;
    localparam int SEL_W         = 2;

    // colour order on the line
    localparam logic [SEL_W-1:0] COL_GREEN = 2'd0;
    localparam logic [SEL_W-1:0] COL_RED   = 2'd1;
    localparam logic [SEL_W-1:0] COL_BLUE  = 2'd2;

    // line byte order inside one expanded colour byte
    localparam logic [SEL_W-1:0] BYT_HIGH = 2'd0;
    localparam logic [SEL_W-1:0] BYT_MID  = 2'd1;
    localparam logic [SEL_W-1:0] BYT_LOW  = 2'd2;

    localparam logic [2:0] LINE_ONE  = 3'b110;
    localparam logic [2:0] LINE_ZERO = 3'b100;

    localparam logic REQ_SET_ONE = 1'b0;
    localparam logic REQ_SET_ALL = 1'b1;

    typedef struct packed {
        logic             write;
        logic             load;
        logic             last;
        logic [PIX_W-1:0] pix;
        logic [SEL_W-1:0] col;
        logic [SEL_W-1:0] byt;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // each data bit becomes three line bits, msb first
    function automatic logic [23:0] expand_byte(input logic [7:0] v);
        logic [23:0] w;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            w[3*i +: 3] = v[i] ? LINE_ONE : LINE_ZERO;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/lsfe_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_in_if
// request channel: pixel update beats
// ----------------------------------------------------------------------------
interface lsfe_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [2:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, req_type, pixel_index, red, green, blue, input ready);
    modport sink   (input valid, req_type, pixel_index, red, green, blue, output ready);
endinterface

// ===== rtl/core/lsfe_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_out_if
// line channel: encoded spi byte beats
// ----------------------------------------------------------------------------
interface lsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] spi_byte;
    logic       frame_last;

    modport source (output valid, spi_byte, frame_last, input ready);
    modport sink   (input valid, spi_byte, frame_last, output ready);
endinterface

// ===== rtl/core/led_strip_frame_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_frame_encoder
// pixel color store with a 3-bit-per-bit spi line encoder for rgb led strips
// ----------------------------------------------------------------------------
// flow: a request beat moves the sequencer into send, then each load fills the
//   single output register, one line byte per cycle while the sink is ready;
//   the next request is taken only after the final line byte is loaded,
//   and the request beat itself loads no line byte
// reset: synchronous active low, clears every pixel color, sequencer to idle
//   and the output register to empty
// ----------------------------------------------------------------------------
module led_strip_frame_encoder #(
    parameter int LED_COUNT = lsfe_pkg::LED_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lsfe_in_if.sink           i_req,
    lsfe_out_if.source        o_line
);

    // command and status between sequencer and datapath
    lsfe_pkg::t_cmd    cmd;
    lsfe_pkg::t_status status;

    // sequencer: takes one request beat, then walks pixels in index order,
    // colors green, red, blue, and three line bytes per color byte
    lsfe_ctrl #(
        .LED_COUNT (LED_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath: store update on the request beat, then one encoded byte per
    // load into the output register; the next request can be taken while the
    // final byte still waits there
    lsfe_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_req_type    (i_req.req_type),
        .i_pixel_index (i_req.pixel_index),
        .i_red         (i_req.red),
        .i_green       (i_req.green),
        .i_blue        (i_req.blue),
        .o_valid       (o_line.valid),
        .i_ready       (o_line.ready),
        .o_spi_byte    (o_line.spi_byte),
        .o_frame_last  (o_line.frame_last)
    );

endmodule

// ===== rtl/core/lsfe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_ctrl
// sequencer: takes a request, then steps pixel, colour and line byte
// ----------------------------------------------------------------------------
module lsfe_ctrl #(
    parameter int LED_COUNT = lsfe_pkg::LED_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lsfe_pkg::t_status i_status,
    output lsfe_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    logic [lsfe_pkg::PIX_W-1:0]   r_pix, n_pix;
    logic [lsfe_pkg::SEL_W-1:0]   r_col, n_col;
    logic [lsfe_pkg::SEL_W-1:0]   r_byt, n_byt;
    logic                         accept;
    logic                         last_pix;
    logic                         last_beat;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign last_pix    = ({1'b0, r_pix} == lsfe_pkg::CNT_W'(LED_COUNT - 1));
    assign last_beat   = last_pix && (r_col == lsfe_pkg::COL_BLUE)
                         && (r_byt == lsfe_pkg::BYT_LOW);

    always_comb begin
        n_state     = r_state;
        n_pix       = r_pix;
        n_col       = r_col;
        n_byt       = r_byt;
        o_cmd.write = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.last  = 1'b0;
        o_cmd.pix   = r_pix;
        o_cmd.col   = r_col;
        o_cmd.byt   = r_byt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.write = 1'b1;
                    n_state     = ST_SEND;
                    n_pix       = '0;
                    n_col       = lsfe_pkg::COL_GREEN;
                    n_byt       = lsfe_pkg::BYT_HIGH;
                end
            end
            ST_SEND: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.last = last_beat;
                    if (r_byt != lsfe_pkg::BYT_LOW) begin
                        n_byt = r_byt + 1'b1;
                    end else begin
                        n_byt = lsfe_pkg::BYT_HIGH;
                        if (r_col != lsfe_pkg::COL_BLUE) begin
                            n_col = r_col + 1'b1;
                        end else begin
                            n_col = lsfe_pkg::COL_GREEN;
                            n_pix = r_pix + 1'b1;
                        end
                    end
                    if (last_beat) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pix   <= '0;
            r_col   <= lsfe_pkg::COL_GREEN;
            r_byt   <= lsfe_pkg::BYT_HIGH;
        end else begin
            r_state <= n_state;
            r_pix   <= n_pix;
            r_col   <= n_col;
            r_byt   <= n_byt;
        end
    end

    // a load only happens mid-frame with room at the output
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == ST_SEND) && i_status.out_free)
        else $error("load issued outside send or without room");

    // a new frame starts at the first byte of the first pixel
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_pix == '0) && (r_col == lsfe_pkg::COL_GREEN)
                   && (r_byt == lsfe_pkg::BYT_HIGH))
        else $error("frame did not start at first byte");

    // the final beat frees the request side
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && o_cmd.last) |=> o_req_ready)
        else $error("not ready after final beat");

endmodule

// ===== rtl/core/lsfe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfe_dp
// pixel store, line-bit expansion and output register
// ----------------------------------------------------------------------------
module lsfe_dp #(
    parameter int LED_COUNT = lsfe_pkg::LED_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsfe_pkg::t_cmd    i_cmd,
    output lsfe_pkg::t_status o_status,
    input  logic              i_req_type,
    input  logic [2:0]        i_pixel_index,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_blue,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_spi_byte,
    output logic              o_frame_last
);

    logic [lsfe_pkg::COLOUR_W-1:0] r_store [lsfe_pkg::STORE_DEPTH];
    logic                          r_valid;
    logic [7:0]                    r_byte;
    logic                          r_last;
    logic [lsfe_pkg::COLOUR_W-1:0] colour_in;
    logic [lsfe_pkg::COLOUR_W-1:0] colour_rd;
    logic [7:0]                    chan;
    logic [23:0]                   line_bits;
    logic [7:0]                    line_byte;
    logic                          idx_ok;

    assign colour_in = {i_red, i_green, i_blue};
    assign idx_ok    = ({1'b0, i_pixel_index} < lsfe_pkg::CNT_W'(LED_COUNT));
    assign colour_rd = r_store[i_cmd.pix];
    assign o_status.out_free = !r_valid || i_ready;

    always_comb begin
        case (i_cmd.col)
            lsfe_pkg::COL_GREEN: chan = colour_rd[15:8];
            lsfe_pkg::COL_RED:   chan = colour_rd[23:16];
            default:             chan = colour_rd[7:0];
        endcase
    end

    assign line_bits = lsfe_pkg::expand_byte(chan);

    always_comb begin
        case (i_cmd.byt)
            lsfe_pkg::BYT_HIGH: line_byte = line_bits[23:16];
            lsfe_pkg::BYT_MID:  line_byte = line_bits[15:8];
            default:            line_byte = line_bits[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < lsfe_pkg::STORE_DEPTH; p++) begin
                r_store[p] <= '0;
            end
        end else if (i_cmd.write) begin
            if (i_req_type == lsfe_pkg::REQ_SET_ALL) begin
                for (int p = 0; p < lsfe_pkg::STORE_DEPTH; p++) begin
                    if (p < LED_COUNT) begin
                        r_store[p] <= colour_in;
                    end
                end
            end else if (idx_ok) begin
                r_store[i_pixel_index] <= colour_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= line_byte;
            r_last <= i_cmd.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_spi_byte   = r_byte;
    assign o_frame_last = r_last;

    // a loaded final beat shows up marked at the output
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.last) |=> r_valid && r_last)
        else $error("final beat not marked");

endmodule
